@@ design/text_console_scrollback_macros.svh @@
// assertion macros used by the console top level
`ifndef TEXT_CONSOLE_SCROLLBACK_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_MACROS_SVH

// same-cycle implication, checked on clk and held off during reset
`define TCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk and held off during reset
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tcs_pkg.sv @@
// types and constants of the text console with scrollback
`default_nettype none
package tcs_pkg;

    // request codes
    localparam logic [2:0] REQ_PUT    = 3'd0;
    localparam logic [2:0] REQ_UP     = 3'd1;
    localparam logic [2:0] REQ_DOWN   = 3'd2;
    localparam logic [2:0] REQ_BOTTOM = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;
    localparam logic [2:0] REQ_FRAME  = 3'd5;
    localparam logic [2:0] REQ_READ   = 3'd6;
    // spare code, changes nothing and reports the status
    localparam logic [2:0] REQ_SPARE  = 3'd7;

    // character classes
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

    // register indexes (address bit 2)
    localparam logic REG_PANE_WIDTH  = 1'b0;
    localparam logic REG_PANE_HEIGHT = 1'b1;

    localparam logic [11:0] PANE_WIDTH_RST  = 12'd640;
    localparam logic [11:0] PANE_HEIGHT_RST = 12'd480;

    // widths that cover the whole parameter range
    localparam int VIS_COLS_W = 9;
    localparam int VIS_ROWS_W = 8;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [11:0] scroll_rows;
        logic [5:0]  read_row;
        logic [6:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic       row_shown;
        logic       dirty;
        logic [7:0] view_offset;
        logic [7:0] scroll_limit;
    } out_item_t;

    // classified request between front and back
    typedef struct packed {
        logic [2:0]  op;
        logic        is_newline;
        logic        is_print;
        logic [7:0]  char_code;
        logic [11:0] scroll_rows;
        logic [5:0]  read_row;
        logic [6:0]  read_col;
    } cmd_t;

    // pane geometry in character cells
    typedef struct packed {
        logic                  ready;
        logic [VIS_COLS_W-1:0] vis_cols;
        logic [VIS_ROWS_W-1:0] vis_rows;
    } geom_t;

endpackage
`default_nettype wire

@@ design/text_console_scrollback.sv @@
// top level of the text console with a ring of scrollback lines
//
//  port group   direction  handshake                 payload
//  request      in         push / full               tcs_pkg::in_item_t
//  result       out        pop / empty               tcs_pkg::out_item_t
//  config       in         psel, penable, pwrite     paddr, pwdata, prdata
//
// put-char, scroll, frame and clear items pass the exec and emit states of
// the sequencer, read-cell items also rd_b, rd_c and rd_d; a new line or a
// clear adds a wipe of MAX_COLS cells through the single write port of the
// line store; after reset it wipes line 0 the same way with full held high
// a register write rebuilds the geometry by estimate and fix; items wait
// the request and result queues hold two items each, so either side may stall
`default_nettype none
`include "text_console_scrollback_macros.svh"
module text_console_scrollback #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int RING_LINES  = 256,
    parameter int GLYPH_WIDTH = 8,
    parameter int LINE_HEIGHT = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire tcs_pkg::in_item_t  request,
    output logic                    empty,
    input  wire logic               pop,
    output tcs_pkg::out_item_t      result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import tcs_pkg::*;

    logic [11:0] pane_width_reg, pane_width_next;
    logic [11:0] pane_height_reg, pane_height_next;
    logic        cfg_we;
    cmd_t        cmd;
    logic        cmd_valid, cmd_pop;
    geom_t       geom;
    out_item_t   res;
    logic        res_push, res_full;
    logic        init_busy;

    // configuration port, no wait states
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        pane_width_next  = pane_width_reg;
        pane_height_next = pane_height_reg;
        if (cfg_we)
        begin
            unique case (paddr[2])
                REG_PANE_WIDTH:  pane_width_next  = pwdata[11:0];
                REG_PANE_HEIGHT: pane_height_next = pwdata[11:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PANE_WIDTH:  prdata = {20'd0, pane_width_reg};
            REG_PANE_HEIGHT: prdata = {20'd0, pane_height_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pane_width_reg  <= PANE_WIDTH_RST;
            pane_height_reg <= PANE_HEIGHT_RST;
        end
        else
        begin
            pane_width_reg  <= pane_width_next;
            pane_height_reg <= pane_height_next;
        end
    end

    // front: classify and queue incoming items
    tcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .hold      (init_busy),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // visible columns and rows, rebuilt after every register write
    tcs_geom #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .GLYPH_WIDTH (GLYPH_WIDTH),
        .LINE_HEIGHT (LINE_HEIGHT)
    ) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cfg_we),
        .pane_width  (pane_width_reg),
        .pane_height (pane_height_reg),
        .geom        (geom)
    );

    // back: sequencer over the line store
    tcs_back #(
        .MAX_COLS   (MAX_COLS),
        .RING_LINES (RING_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .geom      (geom),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full),
        .init_busy (init_busy)
    );

    // result queue decouples the sequencer from the consumer
    tcs_fifo #(.WIDTH($bits(out_item_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    `TCS_ASSERT_NOW(a_res_room, res_push, !res_full, "result pushed into a full queue")
    `TCS_ASSERT_NOW(a_pop_ready, cmd_pop, cmd_valid && geom.ready, "item started without geometry")
    `TCS_ASSERT_NEXT(a_geom_restart, cfg_we, !geom.ready, "geometry not rebuilt after write")
    `TCS_ASSERT_NOW(a_init_hold, init_busy, full, "item taken while store is wiped")
endmodule
`default_nettype wire

@@ design/tcs_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ design/tcs_fifo.sv @@
// two-entry queue of fixed-width items
`default_nettype none
module tcs_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

@@ design/tcs_front.sv @@
// front end: takes request items, classifies them and queues them
`default_nettype none
module tcs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tcs_pkg::in_item_t request,
    output logic                   full,
    input  wire logic              hold,
    output tcs_pkg::cmd_t          cmd,
    output logic                   cmd_valid,
    input  wire logic              cmd_pop
);
    import tcs_pkg::*;

    cmd_t cmd_in;
    logic q_full, q_empty;

    always_comb
    begin
        cmd_in.op          = request.req_type;
        cmd_in.is_newline  = (request.char_code == CHAR_NEWLINE);
        cmd_in.is_print    = (request.char_code >= CHAR_PRINT_LO) &&
                             (request.char_code <= CHAR_PRINT_HI);
        cmd_in.char_code   = request.char_code;
        cmd_in.scroll_rows = request.scroll_rows;
        cmd_in.read_row    = request.read_row;
        cmd_in.read_col    = request.read_col;
    end

    // no item taken while the store is being cleared after reset
    assign full      = q_full || hold;
    assign cmd_valid = !q_empty;

    tcs_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .wdata (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (q_empty)
    );
endmodule
`default_nettype wire

@@ design/tcs_geom.sv @@
// pane geometry: visible columns and rows by reciprocal multiplication and a remainder fix
`default_nettype none
module tcs_geom #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int GLYPH_WIDTH = 8,
    parameter int LINE_HEIGHT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [11:0] pane_width,
    input  wire logic [11:0] pane_height,
    output tcs_pkg::geom_t   geom
);
    import tcs_pkg::*;

    localparam int          SHIFT   = 12;
    localparam logic [12:0] RECIP_W = 13'((2 ** SHIFT) / GLYPH_WIDTH);
    localparam logic [12:0] RECIP_H = 13'((2 ** SHIFT) / LINE_HEIGHT);
    localparam logic [6:0]  GW      = 7'(GLYPH_WIDTH);
    localparam logic [6:0]  LH      = 7'(LINE_HEIGHT);

    logic                  busy_reg, busy_next;
    logic                  step_reg, step_next;
    logic [11:0]           qw_reg, qw_next;
    logic [11:0]           qh_reg, qh_next;
    logic [VIS_COLS_W-1:0] cols_reg, cols_next;
    logic [VIS_ROWS_W-1:0] rows_reg, rows_next;
    logic [23:0]           prod_w, prod_h;
    logic [18:0]           back_w, back_h, rem_w, rem_h;
    logic [11:0]           qw_fix, qh_fix;

    // estimate is exact or one short, the remainder check fixes it
    always_comb
    begin
        prod_w = 24'(pane_width) * 24'(RECIP_W);
        prod_h = 24'(pane_height) * 24'(RECIP_H);
        back_w = 19'(qw_reg) * 19'(GW);
        back_h = 19'(qh_reg) * 19'(LH);
        rem_w  = 19'(pane_width) - back_w;
        rem_h  = 19'(pane_height) - back_h;
        qw_fix = (rem_w >= 19'(GW)) ? qw_reg + 12'd1 : qw_reg;
        qh_fix = (rem_h >= 19'(LH)) ? qh_reg + 12'd1 : qh_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        qw_next   = qw_reg;
        qh_next   = qh_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                qw_next   = prod_w[SHIFT +: 12];
                qh_next   = prod_h[SHIFT +: 12];
                step_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                step_next = 1'b0;
                if (qw_fix > 12'(MAX_COLS))
                    cols_next = VIS_COLS_W'(MAX_COLS);
                else if (qw_fix == 12'd0)
                    cols_next = VIS_COLS_W'(1);
                else
                    cols_next = VIS_COLS_W'(qw_fix);
                if (qh_fix > 12'(MAX_ROWS))
                    rows_next = VIS_ROWS_W'(MAX_ROWS);
                else
                    rows_next = VIS_ROWS_W'(qh_fix);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qw_reg   <= qw_next;
        qh_reg   <= qh_next;
        cols_reg <= cols_next;
        rows_reg <= rows_next;
    end

    assign geom.ready    = !busy_reg;
    assign geom.vis_cols = cols_reg;
    assign geom.vis_rows = rows_reg;
endmodule
`default_nettype wire

@@ design/tcs_back.sv @@
// back end: sequencer that carries out requests on the line store
`default_nettype none
module tcs_back #(
    parameter int MAX_COLS   = 128,
    parameter int RING_LINES = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcs_pkg::cmd_t   cmd,
    input  wire logic            cmd_valid,
    output logic                 cmd_pop,
    input  wire tcs_pkg::geom_t  geom,
    output tcs_pkg::out_item_t   res,
    output logic                 res_push,
    input  wire logic            res_full,
    output logic                 init_busy
);
    import tcs_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CUR_W  = $clog2(MAX_COLS + 1);
    localparam int LINE_W = $clog2(RING_LINES);
    localparam int HELD_W = $clog2(RING_LINES + 1);
    localparam int CMP_W  = (HELD_W > VIS_ROWS_W) ? HELD_W : VIS_ROWS_W;
    localparam int ADDR_W = LINE_W + COL_W;
    localparam int DEPTH  = RING_LINES * (2 ** COL_W);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RD_B  = 7'b0000100,
        S_RD_C  = 7'b0001000,
        S_RD_D  = 7'b0010000,
        S_SWEEP = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [LINE_W-1:0]     wl_reg, wl_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [CUR_W-1:0]      cursor_reg, cursor_next;
    logic [LINE_W-1:0]     off_reg, off_next;
    logic                  dirty_reg, dirty_next;
    logic [LINE_W-1:0]     lim_reg, lim_next;
    logic [COL_W-1:0]      sweep_reg, sweep_next;
    logic                  emit_pend_reg, emit_pend_next;
    logic [7:0]            rd_char_reg, rd_char_next;
    logic                  rd_shown_reg, rd_shown_next;
    logic [LINE_W-1:0]     eff_reg, eff_next;
    logic [HELD_W-1:0]     avail_reg, avail_next;
    logic                  hit_reg, hit_next;
    logic [7:0]            dist_reg, dist_next;
    logic                  cell_ok_reg, cell_ok_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    logic [CMP_W-1:0]      held_c, rows_c, lim_c, avail_c, shown_c;
    logic [LINE_W-1:0]     wl_inc, eff_c;
    logic [CUR_W-1:0]      cur_inc;
    logic                  wrap;
    logic [LINE_W:0]       back_c, tmp_c;
    logic [LINE_W-1:0]     slot_c;
    logic [7:0]            shown8;

    // offset limit, registered each cycle
    always_comb
    begin
        held_c = CMP_W'(held_reg);
        rows_c = CMP_W'(geom.vis_rows);
        lim_c  = (held_c > rows_c) ? held_c - rows_c : '0;
        if (lim_c > CMP_W'(RING_LINES - 1))
            lim_next = LINE_W'(RING_LINES - 1);
        else
            lim_next = LINE_W'(lim_c);
    end

    always_comb
    begin
        wl_inc  = (wl_reg == LINE_W'(RING_LINES - 1)) ? '0 : wl_reg + LINE_W'(1);
        cur_inc = cmd_reg.is_print ? cursor_reg + CUR_W'(1) : cursor_reg;
        wrap    = cmd_reg.is_newline || (VIS_COLS_W'(cur_inc) >= geom.vis_cols);
        eff_c   = (off_reg < lim_reg) ? off_reg : lim_reg;
        avail_c = (CMP_W'(held_reg) > CMP_W'(eff_reg)) ?
                  CMP_W'(held_reg) - CMP_W'(eff_reg) : '0;
        shown_c = (CMP_W'(avail_reg) < CMP_W'(geom.vis_rows)) ?
                  CMP_W'(avail_reg) : CMP_W'(geom.vis_rows);
        shown8  = 8'(shown_c);
        back_c  = (LINE_W + 1)'(eff_reg) + (LINE_W + 1)'(dist_reg);
        tmp_c   = {1'b0, wl_reg} + (LINE_W + 1)'(RING_LINES) - back_c;
        slot_c  = (tmp_c >= (LINE_W + 1)'(RING_LINES)) ?
                  LINE_W'(tmp_c - (LINE_W + 1)'(RING_LINES)) : LINE_W'(tmp_c);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        wl_next        = wl_reg;
        held_next      = held_reg;
        cursor_next    = cursor_reg;
        off_next       = off_reg;
        dirty_next     = dirty_reg;
        sweep_next     = sweep_reg;
        emit_pend_next = emit_pend_reg;
        rd_char_next   = rd_char_reg;
        rd_shown_next  = rd_shown_reg;
        eff_next       = eff_reg;
        avail_next     = avail_reg;
        hit_next       = hit_reg;
        dist_next      = dist_reg;
        cell_ok_next   = cell_ok_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {wl_reg, sweep_reg};
        ram_wdata      = 8'd0;
        ram_raddr      = {slot_c, COL_W'(cmd_reg.read_col)};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && geom.ready)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rd_char_next  = 8'd0;
                rd_shown_next = 1'b0;
                state_next    = S_EMIT;
                unique case (cmd_reg.op)
                    REQ_PUT:
                    begin
                        dirty_next = 1'b1;
                        if (cmd_reg.is_print && (cursor_reg < CUR_W'(MAX_COLS)))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = {wl_reg, COL_W'(cursor_reg)};
                            ram_wdata = cmd_reg.char_code;
                        end
                        cursor_next = cur_inc;
                        if (wrap)
                        begin
                            // fresh line: advance the ring and wipe the reused slot
                            cursor_next    = '0;
                            wl_next        = wl_inc;
                            if (held_reg < HELD_W'(RING_LINES))
                                held_next = held_reg + HELD_W'(1);
                            sweep_next     = '0;
                            emit_pend_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                    end
                    REQ_UP:
                    begin
                        if (off_reg < lim_reg)
                        begin
                            dirty_next = 1'b1;
                            if (12'(lim_reg - off_reg) < cmd_reg.scroll_rows)
                                off_next = lim_reg;
                            else
                                off_next = off_reg + LINE_W'(cmd_reg.scroll_rows);
                        end
                    end
                    REQ_DOWN:
                    begin
                        if (off_reg != '0)
                        begin
                            dirty_next = 1'b1;
                            if (12'(off_reg) < cmd_reg.scroll_rows)
                                off_next = '0;
                            else
                                off_next = off_reg - LINE_W'(cmd_reg.scroll_rows);
                        end
                    end
                    REQ_BOTTOM:
                    begin
                        if (off_reg != '0)
                        begin
                            dirty_next = 1'b1;
                            off_next   = '0;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        // only line 0 is wiped; every later line is wiped as it opens
                        wl_next        = '0;
                        held_next      = HELD_W'(1);
                        cursor_next    = '0;
                        off_next       = '0;
                        dirty_next     = 1'b1;
                        sweep_next     = '0;
                        emit_pend_next = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    REQ_FRAME:
                    begin
                        if (off_reg > lim_reg)
                            off_next = lim_reg;
                        dirty_next = 1'b0;
                    end
                    REQ_READ:
                    begin
                        eff_next   = eff_c;
                        state_next = S_RD_B;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD_B:
            begin
                // avail from the clamped offset
                avail_next = HELD_W'(avail_c);
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                hit_next   = (8'(cmd_reg.read_row) < shown8);
                dist_next  = shown8 - 8'd1 - 8'(cmd_reg.read_row);
                state_next = S_RD_D;
            end
            S_RD_D:
            begin
                // ring slot of the row, read issued this cycle
                cell_ok_next = hit_reg && (9'(cmd_reg.read_col) < 9'(MAX_COLS));
                rd_shown_next = hit_reg;
                state_next    = S_EMIT;
                emit_pend_next = 1'b0;
            end
            S_SWEEP:
            begin
                ram_we = 1'b1;
                if (sweep_reg == COL_W'(MAX_COLS - 1))
                begin
                    state_next     = emit_pend_reg ? S_EMIT : S_IDLE;
                    emit_pend_next = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + COL_W'(1);
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read data arrives in the cycle after the address
    always_comb
    begin
        res.read_char    = cell_ok_reg ? ram_rdata : rd_char_reg;
        res.row_shown    = rd_shown_reg;
        res.dirty        = dirty_reg;
        res.view_offset  = 8'(off_reg);
        res.scroll_limit = 8'(lim_reg);
    end

    assign init_busy = (state_reg == S_SWEEP) && !emit_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            wl_reg        <= '0;
            held_reg      <= HELD_W'(1);
            cursor_reg    <= '0;
            off_reg       <= '0;
            dirty_reg     <= 1'b1;
            lim_reg       <= '0;
            sweep_reg     <= '0;
            emit_pend_reg <= 1'b0;
            cell_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            held_reg      <= held_next;
            cursor_reg    <= cursor_next;
            off_reg       <= off_next;
            dirty_reg     <= dirty_next;
            lim_reg       <= lim_next;
            sweep_reg     <= sweep_next;
            emit_pend_reg <= emit_pend_next;
            cell_ok_reg   <= (state_reg == S_EMIT) ? cell_ok_reg && !res_push
                                                   : cell_ok_next && (state_reg == S_RD_D);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_char_reg  <= rd_char_next;
        rd_shown_reg <= rd_shown_next;
        eff_reg      <= eff_next;
        avail_reg    <= avail_next;
        hit_reg      <= hit_next;
        dist_reg     <= dist_next;
    end

    tcs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// testbench for the text console with scrollback: directed and random requests checked against a predictor
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcs_pkg::*;

    localparam int COLS  = 128;
    localparam int ROWS  = 64;
    localparam int RING  = 256;
    localparam int GLYPH = 8;
    localparam int LINEH = 16;
    localparam int ITEM_W = $bits(in_item_t);
    // a new line wipes COLS cells, so allow that and some slack before a register write
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    request;
    logic        empty;
    logic        pop;
    out_item_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_console_scrollback uut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .request(request),
        .empty(empty), .pop(pop), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // items waiting to be offered, and results the console owes us
    in_item_t  pending_items[$];
    out_item_t owed_results[$];
    int        fail_count = 0;
    logic      hold_sender = 1'b1;
    logic      no_idling   = 1'b0;

    // predictor copy of the console state
    logic [7:0] cells[RING][COLS];
    int         newest_line;
    int         held;
    int         cursor;
    int         offset;
    logic       dirty_now;
    int         width_px;
    int         height_px;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pane_cols();
        int c;
        c = width_px / GLYPH;
        if (c > COLS)
            c = COLS;
        if (c < 1)
            c = 1;
        return c;
    endfunction

    function automatic int pane_rows();
        int r;
        r = height_px / LINEH;
        if (r > ROWS)
            r = ROWS;
        return r;
    endfunction

    function automatic int scroll_ceiling();
        int rows;
        int lim;
        rows = pane_rows();
        lim = (held > rows) ? held - rows : 0;
        if (lim > RING - 1)
            lim = RING - 1;
        return lim;
    endfunction

    task automatic wipe_console();
        for (int l = 0; l < RING; l++)
            for (int c = 0; c < COLS; c++)
                cells[l][c] = 8'h00;
        newest_line = 0;
        held = 1;
        cursor = 0;
        offset = 0;
        dirty_now = 1'b1;
    endtask

    // moving to a fresh line reuses and clears the next ring slot
    task automatic open_line();
        cursor = 0;
        newest_line = (newest_line + 1) % RING;
        if (held < RING)
            held++;
        for (int c = 0; c < COLS; c++)
            cells[newest_line][c] = 8'h00;
        dirty_now = 1'b1;
    endtask

    task automatic predict_console(input in_item_t it);
        out_item_t o;
        int lim;
        int eff;
        int avail;
        int shown;
        int back;
        int slot;
        o = '0;
        case (it.req_type)
            REQ_PUT:
            begin
                if (it.char_code == CHAR_NEWLINE)
                    open_line();
                else if (it.char_code >= CHAR_PRINT_LO && it.char_code <= CHAR_PRINT_HI)
                begin
                    if (cursor < COLS)
                        cells[newest_line][cursor] = it.char_code;
                    cursor++;
                end
                // wraps even for ignored bytes once the pane has shrunk
                if (cursor >= pane_cols())
                    open_line();
                dirty_now = 1'b1;
            end
            REQ_UP:
            begin
                lim = scroll_ceiling();
                if (offset < lim)
                begin
                    offset = (lim - offset < it.scroll_rows) ? lim : offset + it.scroll_rows;
                    dirty_now = 1'b1;
                end
            end
            REQ_DOWN:
            begin
                if (offset != 0)
                begin
                    offset = (offset < it.scroll_rows) ? 0 : offset - it.scroll_rows;
                    dirty_now = 1'b1;
                end
            end
            REQ_BOTTOM:
            begin
                if (offset != 0)
                begin
                    offset = 0;
                    dirty_now = 1'b1;
                end
            end
            REQ_CLEAR:
                wipe_console();
            REQ_FRAME:
            begin
                lim = scroll_ceiling();
                if (offset > lim)
                    offset = lim;
                dirty_now = 1'b0;
            end
            REQ_READ:
            begin
                // the read uses a clamped offset but leaves the stored one alone
                lim = scroll_ceiling();
                eff = (offset > lim) ? lim : offset;
                avail = (held > eff) ? held - eff : 0;
                shown = (avail < pane_rows()) ? avail : pane_rows();
                if (it.read_row < shown)
                begin
                    back = eff + (shown - 1 - it.read_row);
                    slot = (newest_line + RING - (back % RING)) % RING;
                    o.row_shown = 1'b1;
                    o.read_char = cells[slot][it.read_col];
                end
            end
            default: ;
        endcase
        o.dirty = dirty_now;
        o.view_offset = offset[7:0];
        o.scroll_limit = 8'(scroll_ceiling());
        owed_results.push_back(o);
    endtask

    function automatic logic idle_now();
        return !no_idling && ($urandom_range(99) < 24);
    endfunction

    // sender: offers the head of the pending list, keeps it up until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_console(request);
                void'(pending_items.pop_front());
            end
            if (!push || !full)
            begin
                if (!hold_sender && pending_items.size() > 0 && !idle_now())
                begin
                    push <= 1'b1;
                    request <= pending_items[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver: random pop, each taken item checked field by field
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result with nothing owed: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.read_char !== want.read_char)
                    begin
                        $error("read_char expected %0h got %0h", want.read_char, result.read_char);
                        fail_count++;
                    end
                    if (result.row_shown !== want.row_shown)
                    begin
                        $error("row_shown expected %0d got %0d", want.row_shown, result.row_shown);
                        fail_count++;
                    end
                    if (result.dirty !== want.dirty)
                    begin
                        $error("dirty expected %0d got %0d", want.dirty, result.dirty);
                        fail_count++;
                    end
                    if (result.view_offset !== want.view_offset)
                    begin
                        $error("view_offset expected %0d got %0d",
                               want.view_offset, result.view_offset);
                        fail_count++;
                    end
                    if (result.scroll_limit !== want.scroll_limit)
                    begin
                        $error("scroll_limit expected %0d got %0d",
                               want.scroll_limit, result.scroll_limit);
                        fail_count++;
                    end
                end
            end
            pop <= !idle_now();
        end
    end

    function automatic in_item_t make_item(input logic [2:0] op, input logic [7:0] ch,
                                           input logic [11:0] rows, input logic [5:0] r,
                                           input logic [6:0] c);
        in_item_t it;
        it.req_type = op;
        it.char_code = ch;
        it.scroll_rows = rows;
        it.read_row = r;
        it.read_col = c;
        return it;
    endfunction

    // mostly text and newlines with scrolling and reads, a little noise
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it = ITEM_W'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            it.req_type = REQ_PUT;
            it.char_code = 8'($urandom_range(8'h20, 8'h7E));
        end
        else if (pick < 60)
        begin
            it.req_type = REQ_PUT;
            it.char_code = CHAR_NEWLINE;
        end
        else if (pick < 64)
            it.req_type = REQ_PUT;
        else if (pick < 71)
        begin
            it.req_type = REQ_UP;
            if ($urandom_range(1))
                it.scroll_rows = 12'($urandom_range(20));
        end
        else if (pick < 76)
        begin
            it.req_type = REQ_DOWN;
            if ($urandom_range(1))
                it.scroll_rows = 12'($urandom_range(20));
        end
        else if (pick < 78)
            it.req_type = REQ_BOTTOM;
        else if (pick < 82)
            it.req_type = REQ_FRAME;
        else if (pick < 97)
        begin
            it.req_type = REQ_READ;
            if ($urandom_range(1))
                it.read_col = 7'($urandom_range(10));
            if ($urandom_range(1))
                it.read_row = 6'($urandom_range(pane_rows() > 0 ? pane_rows() : 1));
        end
        else if (pick < 98)
            it.req_type = REQ_CLEAR;
        else
            it.req_type = REQ_SPARE;
        return it;
    endfunction

    // let the sender go and wait until every owed result is back
    task automatic drain();
        hold_sender = 1'b0;
        while (pending_items.size() > 0 || push || owed_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [11:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {20'($urandom_range(1048575)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_PANE_WIDTH)
            width_px = value;
        else
            height_px = value;
    endtask

    task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input int count,
                             input logic quiet);
        write_reg({REG_PANE_WIDTH, 2'b00}, w);
        write_reg({REG_PANE_HEIGHT, 2'b00}, h);
        repeat (SETTLE_CYCLES) @(posedge clk);
        no_idling = quiet;
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
        drain();
        no_idling = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        width_px = PANE_WIDTH_RST;
        height_px = PANE_HEIGHT_RST;
        wipe_console();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // directed: character extremes, ignored bytes, every request and scroll extremes
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'h41, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, CHAR_PRINT_LO, 12'hFFF, 6'h3F, 7'h7F));
        pending_items.push_back(make_item(REQ_PUT, CHAR_PRINT_HI, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'h1F, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'h7F, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'hFF, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, CHAR_NEWLINE, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_PUT, 8'h5A, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_FRAME, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_UP, 8'h00, 12'hFFF, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_UP, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_DOWN, 8'h00, 12'd1, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_DOWN, 8'h00, 12'hFFF, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_BOTTOM, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'd1, 7'd0));
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'h3F, 7'h7F));
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'd0, 7'h7F));
        pending_items.push_back(make_item(REQ_SPARE, 8'hFF, 12'hFFF, 6'h3F, 7'h7F));
        pending_items.push_back(make_item(REQ_CLEAR, 8'h00, 12'd0, 6'd0, 7'd0));
        pending_items.push_back(make_item(REQ_READ, 8'h00, 12'd0, 6'd0, 7'd1));
        for (int i = 0; i < 80; i++)
            pending_items.push_back(random_item());
        drain();

        // one column: every printable character wraps onto a fresh ring line
        run_phase(12'd8, 12'd4095, 140, 1'b1);
        // widest pane and no visible rows
        run_phase(12'd4095, 12'd0, 50, 1'b0);
        // shrink the pane under a long line so the cursor is already past the width
        run_phase(12'd1000, 12'd64, 40, 1'b0);
        run_phase(12'd40, 12'd160, 60, 1'b0);
        run_phase(12'd13, 12'd4095, 50, 1'b0);

        if (fail_count == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+design
design/tcs_pkg.sv
design/tcs_ram.sv
design/tcs_fifo.sv
design/tcs_front.sv
design/tcs_geom.sv
design/tcs_back.sv
design/text_console_scrollback.sv
sim/tb.sv
